// ----- rtl/binomial_coefficient_unit_macros.svh -----
// Assertion macros shared by the checker of binomial_coefficient_unit.
// Each macro expects a clock named clock and a reset named reset in scope.
`ifndef BINOMIAL_COEFFICIENT_UNIT_MACROS_SVH
`define BINOMIAL_COEFFICIENT_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BCU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BCU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bcu_pkg.sv -----
// Package for the binomial coefficient unit: word widths, status codes and
// the command and result structs of the shared shift/add unit. No dependencies.
package bcu_pkg;

   localparam int WORD_BITS     = 64;
   localparam int STEP_CNT_BITS = 6;
   localparam int STATUS_BITS   = 2;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_K_GT_N   = 2'd2;

   typedef enum logic {
      OP_DIV,
      OP_MUL
   } unit_op_type;

   typedef struct packed {
      logic                 go;
      unit_op_type          op;
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;
   } unit_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] hi;
      logic [WORD_BITS-1:0] lo;
   } unit_res_type;

endpackage

// ----- rtl/bcu_shared_unit.sv -----
// Shared bit-serial arithmetic unit: 64/64 restoring division or 64x64
// shift-add multiplication, one bit per cycle on a single adder. Uses bcu_pkg.
module bcu_shared_unit
   import bcu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  unit_cmd_type cmd,
   output unit_res_type res
);

   logic                     run_ff;
   logic                     done_ff;
   unit_op_type              op_ff;
   logic [STEP_CNT_BITS-1:0] cnt_ff;
   logic [WORD_BITS-1:0]     b_ff;
   // Division: x is the partial remainder, y the dividend shifting into the
   // quotient. Multiplication: x is the high half, y the multiplier shifting
   // into the low half.
   logic [WORD_BITS-1:0]     x_ff;
   logic [WORD_BITS-1:0]     y_ff;
   logic [WORD_BITS-1:0]     x_in;
   logic [WORD_BITS-1:0]     y_in;

   logic [WORD_BITS:0]       rem_sh;
   logic [WORD_BITS:0]       add_a;
   logic [WORD_BITS-1:0]     add_b;
   logic                     sub;
   logic [WORD_BITS+1:0]     sum;
   logic                     borrow;

   always_comb begin
      rem_sh = {x_ff, y_ff[WORD_BITS-1]};
      sub    = (op_ff == OP_DIV);
      add_a  = sub ? rem_sh : {1'b0, x_ff};
      add_b  = (sub || y_ff[0]) ? b_ff : '0;
      sum    = {1'b0, add_a}
             + (sub ? ~{2'b00, add_b} : {2'b00, add_b})
             + (WORD_BITS+2)'(sub);
      borrow = sum[WORD_BITS+1];
      unique case (op_ff)
         OP_DIV: begin
            x_in = borrow ? rem_sh[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
            y_in = {y_ff[WORD_BITS-2:0], ~borrow};
         end
         OP_MUL: begin
            x_in = sum[WORD_BITS:1];
            y_in = {sum[0], y_ff[WORD_BITS-1:1]};
         end
         default: begin
            x_in = x_ff;
            y_in = y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.go) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == '1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         op_ff  <= cmd.op;
         b_ff   <= cmd.b;
         x_ff   <= '0;
         y_ff   <= cmd.a;
         cnt_ff <= '0;
      end else if (run_ff) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         cnt_ff <= cnt_ff + STEP_CNT_BITS'(1);
      end
   end

   assign res.done = done_ff;
   assign res.hi   = x_ff;
   assign res.lo   = y_ff;

endmodule

// ----- rtl/binomial_coefficient_unit.sv -----
// Binomial coefficient unit: top level with the step sequencer.
// Depends on bcu_pkg and bcu_shared_unit.
//
// Usage. A word (req_total_count = n, req_choose_count = k) is taken at a
// rising edge where start is high and busy is low. Exactly one result word
// follows: rsp_coefficient = C(n,k) and rsp_status (ok, overflow, or k > n),
// shown for one cycle while rsp_valid is high. The receiver cannot hold a
// result off, so nothing here ever waits on the result side.
// Sequence. When n equals k, when k is zero, or when k exceeds n, the result
// appears the cycle after the word is taken and busy never rises. Otherwise
// the block runs up to k steps, stopping early with overflow status when
// q * m needs a 65th bit. Each step issues four operations to the one shared
// bit-serial unit (c / i with remainder, q * m with overflow test, r * m,
// and the division of that by i), each passing through the command and done
// registers, and the S_NEXT state then starts the next step. k is at most
// 2**K_BITS - 1. busy stays high until the cycle the result is shown; the
// next word may be taken in that same cycle. No new word is taken while a
// step sequence runs.
// Reset (synchronous, active high) returns the sequencer to idle, drops busy
// and rsp_valid, and discards any word in progress.
module binomial_coefficient_unit
   import bcu_pkg::*;
#(
   parameter int K_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [WORD_BITS-1:0]   req_total_count,
   input  logic [K_BITS-1:0]      req_choose_count,
   output logic                   rsp_valid,
   output logic [WORD_BITS-1:0]   rsp_coefficient,
   output logic [STATUS_BITS-1:0] rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV1,
      S_MUL1,
      S_MUL2,
      S_DIV2,
      S_NEXT
   } state_type;

   state_type                state_ff;
   unit_cmd_type             cmd_ff;
   unit_res_type             res;

   // Running multiplier m (counts down from n), step index i, and k.
   logic [WORD_BITS-1:0]     m_ff;
   logic [K_BITS-1:0]        i_ff;
   logic [K_BITS-1:0]        k_ff;
   // Running coefficient between steps, c % i, and the low half of (c/i)*m.
   logic [WORD_BITS-1:0]     c_ff;
   logic [K_BITS-1:0]        r_ff;
   logic [WORD_BITS-1:0]     pq_ff;

   logic                     rsp_valid_ff;
   logic [WORD_BITS-1:0]     rsp_coefficient_ff;
   logic [STATUS_BITS-1:0]   rsp_status_ff;

   logic [WORD_BITS-1:0]     k_wide;
   logic [WORD_BITS-1:0]     c_next;

   assign k_wide = WORD_BITS'(req_choose_count);
   assign c_next = pq_ff + res.lo;

   bcu_shared_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_ff.go    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff.go    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_total_count == k_wide) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_coefficient_ff <= WORD_BITS'(1);
                     rsp_status_ff      <= ST_OK;
                  end else if (k_wide > req_total_count) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_coefficient_ff <= '0;
                     rsp_status_ff      <= ST_K_GT_N;
                  end else if (req_choose_count == '0) begin
                     // No steps to run: the empty product is one.
                     rsp_valid_ff       <= 1'b1;
                     rsp_coefficient_ff <= WORD_BITS'(1);
                     rsp_status_ff      <= ST_OK;
                  end else begin
                     m_ff      <= req_total_count;
                     k_ff      <= req_choose_count;
                     i_ff      <= K_BITS'(1);
                     cmd_ff.go <= 1'b1;
                     cmd_ff.op <= OP_DIV;
                     cmd_ff.a  <= WORD_BITS'(1);
                     cmd_ff.b  <= WORD_BITS'(1);
                     state_ff  <= S_DIV1;
                  end
               end
            end
            S_DIV1: begin
               if (res.done) begin
                  // Quotient in lo, remainder (below i) in hi.
                  r_ff      <= res.hi[K_BITS-1:0];
                  cmd_ff.go <= 1'b1;
                  cmd_ff.op <= OP_MUL;
                  cmd_ff.a  <= res.lo;
                  cmd_ff.b  <= m_ff;
                  state_ff  <= S_MUL1;
               end
            end
            S_MUL1: begin
               if (res.done) begin
                  // (c/i) > (2^64-1)/m exactly when (c/i)*m needs a 65th bit.
                  if (res.hi != '0) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_coefficient_ff <= '0;
                     rsp_status_ff      <= ST_OVERFLOW;
                     state_ff           <= S_IDLE;
                  end else begin
                     pq_ff     <= res.lo;
                     cmd_ff.go <= 1'b1;
                     cmd_ff.op <= OP_MUL;
                     cmd_ff.a  <= WORD_BITS'(r_ff);
                     cmd_ff.b  <= m_ff;
                     state_ff  <= S_MUL2;
                  end
               end
            end
            S_MUL2: begin
               if (res.done) begin
                  // The remainder product wraps at 64 bits before dividing.
                  cmd_ff.go <= 1'b1;
                  cmd_ff.op <= OP_DIV;
                  cmd_ff.a  <= res.lo;
                  cmd_ff.b  <= WORD_BITS'(i_ff);
                  state_ff  <= S_DIV2;
               end
            end
            S_DIV2: begin
               if (res.done) begin
                  c_ff <= c_next;
                  if (i_ff == k_ff) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_coefficient_ff <= c_next;
                     rsp_status_ff      <= ST_OK;
                     state_ff           <= S_IDLE;
                  end else begin
                     i_ff     <= i_ff + K_BITS'(1);
                     m_ff     <= m_ff - WORD_BITS'(1);
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_NEXT: begin
               cmd_ff.go <= 1'b1;
               cmd_ff.op <= OP_DIV;
               cmd_ff.a  <= c_ff;
               cmd_ff.b  <= WORD_BITS'(i_ff);
               state_ff  <= S_DIV1;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coefficient_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ----- rtl/bcu_checker.sv -----
// Port-level checker for binomial_coefficient_unit, bound to the top level.
// Depends on bcu_pkg and binomial_coefficient_unit_macros.svh.
`include "binomial_coefficient_unit_macros.svh"

module bcu_checker
   import bcu_pkg::*;
#(
   parameter int K_BITS = 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic [WORD_BITS-1:0]   req_total_count,
   input logic [K_BITS-1:0]      req_choose_count,
   input logic                   rsp_valid,
   input logic [WORD_BITS-1:0]   rsp_coefficient,
   input logic [STATUS_BITS-1:0] rsp_status
);

   logic accepted;
   logic k_gt_n;

   assign accepted = start && !busy;
   assign k_gt_n   = WORD_BITS'(req_choose_count) > req_total_count;

   // A taken word either starts the step sequence or answers at once.
   `BCU_ASSERT_NEXT(a_accept_acts, accepted, busy || rsp_valid, "word taken without effect")
   // A result is shown only once the sequencer is idle again.
   `BCU_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "result shown while busy")
   // The end of a busy stretch always delivers its result.
   `BCU_ASSERT_SAME(a_fell_rsp, $fell(busy), rsp_valid, "busy ended with no result")
   // Failed results carry a zero coefficient and a defined status.
   `BCU_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp_status != ST_OK), (rsp_coefficient == '0) && (rsp_status == ST_OVERFLOW || rsp_status == ST_K_GT_N), "bad failure result")
   // k greater than n is answered in the next cycle with its own status.
   `BCU_ASSERT_NEXT(a_k_gt_n, accepted && k_gt_n, rsp_valid && (rsp_status == ST_K_GT_N), "k > n not reported")

endmodule

bind binomial_coefficient_unit bcu_checker #(
   .K_BITS (K_BITS)
) u_bcu_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_total_count  (req_total_count),
   .req_choose_count (req_choose_count),
   .rsp_valid        (rsp_valid),
   .rsp_coefficient  (rsp_coefficient),
   .rsp_status       (rsp_status)
);
